/* hdl/gai_pkg.sv */
// ----------------------------------------------------------------------------
// gai_pkg: shared definitions for the gyro angle integrator
// Field widths, register indexes, the lane control struct and the
// angle range test that both the lanes and the merge stage use.
// ----------------------------------------------------------------------------
package gai_pkg;

    localparam int RATE_W   = 16;   // raw sample and offset width
    localparam int SUM_W    = 14;   // running sum width
    localparam int ANGLE_W  = 10;   // reported angle width
    localparam int QUOT_W   = 8;    // magnitude of a sample divided by 131 (max 250)
    localparam int CFG_IDX_W = 2;

    localparam int OUTPUT_EVERY_DEF = 3;

    localparam int ANGLE_LIMIT = 360;
    // angle = sum*8/125 leaves the range once |sum| reaches this value
    localparam int SUM_LIMIT = ((ANGLE_LIMIT + 1) * 125 + 7) / 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X = 2'd0,
        REG_OFFSET_Y = 2'd1,
        REG_OFFSET_Z = 2'd2,
        REG_UNUSED   = 2'd3
    } cfg_reg_t;

    // control from the sequencer to every lane
    typedef struct packed {
        logic load_a;   // transfer accepted: capture the quotient
        logic adv_a;    // quotient stage moves on: update the sum
        logic emit_a;   // item in the quotient stage reports angles
    } lane_ctrl_t;

    // true when sum*8/125, truncated toward zero, lies outside +-ANGLE_LIMIT
    function automatic logic sum_out_of_range(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W:0] hi;
        logic signed [SUM_W:0] lo;
        begin
            hi = (SUM_W+1)'(SUM_LIMIT);
            lo = -(SUM_W+1)'(SUM_LIMIT);
            return ($signed({s[SUM_W-1], s}) >= hi) || ($signed({s[SUM_W-1], s}) <= lo);
        end
    endfunction

endpackage

/* hdl/gai_lane.sv */
// ----------------------------------------------------------------------------
// gai_lane: one axis of the integrator
// Offset removal and division by 131 in the first stage, then the
// saturating running sum with clear on an out-of-range report.
// ----------------------------------------------------------------------------
module gai_lane
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  gai_pkg::lane_ctrl_t                  ctrl,
    input  logic signed [gai_pkg::RATE_W-1:0]    rate,
    input  logic signed [gai_pkg::RATE_W-1:0]    offset,
    output logic signed [gai_pkg::SUM_W-1:0]     snap
);

    // ceil(2^24 / 131): exact truncating division for magnitudes up to 2^15
    localparam int          RECIP_SHIFT = 24;
    localparam logic [16:0] RECIP_131   = 17'd128071;
    localparam int          PROD_W      = gai_pkg::RATE_W + 17;

    logic [gai_pkg::RATE_W-1:0]        diff;
    logic                              diff_neg;
    logic [gai_pkg::RATE_W-1:0]        diff_mag;
    logic [PROD_W-1:0]                 prod;

    logic [gai_pkg::QUOT_W-1:0]        qmag_reg;
    logic                              qneg_reg;

    logic signed [gai_pkg::QUOT_W:0]   quot;
    logic signed [gai_pkg::SUM_W:0]    wide_sum;
    logic signed [gai_pkg::SUM_W-1:0]  sat_sum;

    logic signed [gai_pkg::SUM_W-1:0]  sum_reg;
    logic signed [gai_pkg::SUM_W-1:0]  sum_next;
    logic signed [gai_pkg::SUM_W-1:0]  snap_reg;

    // difference wraps to 16 bits before the division
    assign diff     = rate - offset;
    assign diff_neg = diff[gai_pkg::RATE_W-1];
    assign diff_mag = diff_neg ? (~diff + 1'b1) : diff;
    assign prod     = PROD_W'(diff_mag) * PROD_W'(RECIP_131);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_a)
        begin
            qmag_reg <= prod[RECIP_SHIFT +: gai_pkg::QUOT_W];
            qneg_reg <= diff_neg;
        end
    end

    always_comb
    begin
        quot     = qneg_reg ? -$signed({1'b0, qmag_reg}) : $signed({1'b0, qmag_reg});
        wide_sum = $signed({sum_reg[gai_pkg::SUM_W-1], sum_reg})
                 + (gai_pkg::SUM_W+1)'(quot);
        if (wide_sum[gai_pkg::SUM_W] != wide_sum[gai_pkg::SUM_W-1])
            sat_sum = wide_sum[gai_pkg::SUM_W] ? {1'b1, {(gai_pkg::SUM_W-1){1'b0}}}
                                               : {1'b0, {(gai_pkg::SUM_W-1){1'b1}}};
        else
            sat_sum = wide_sum[gai_pkg::SUM_W-1:0];
        sum_next = sum_reg;
        if (ctrl.adv_a)
        begin
            if (ctrl.emit_a && gai_pkg::sum_out_of_range(sat_sum))
                sum_next = '0;
            else
                sum_next = sat_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else
            sum_reg <= sum_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv_a && ctrl.emit_a)
            snap_reg <= sat_sum;
    end

    assign snap = snap_reg;

endmodule

/* hdl/gai_merge.sv */
// ----------------------------------------------------------------------------
// gai_merge: angle conversion and result register
// Scale the three captured sums by 8/125, zero the out-of-range axes
// and pack the result word.
// ----------------------------------------------------------------------------
module gai_merge
(
    input  logic                               clk,
    input  logic                               load,
    input  logic signed [gai_pkg::SUM_W-1:0]   snap_x,
    input  logic signed [gai_pkg::SUM_W-1:0]   snap_y,
    input  logic signed [gai_pkg::SUM_W-1:0]   snap_z,
    output logic [31:0]                        data
);

    // ceil(2^23 / 125) applied to |sum| with the factor 8 folded into the shift
    localparam int          RECIP_SHIFT = 20;
    localparam logic [16:0] RECIP_125   = 17'd67109;
    localparam int          PROD_W      = gai_pkg::SUM_W + 17;
    localparam int          MAG_W       = gai_pkg::ANGLE_W - 1;

    function automatic logic [gai_pkg::ANGLE_W-1:0] to_angle(
        input logic signed [gai_pkg::SUM_W-1:0] s);
        logic                       neg;
        logic [gai_pkg::SUM_W-1:0]  mag;
        logic [PROD_W-1:0]          p;
        logic [MAG_W-1:0]           amag;
        begin
            neg  = s[gai_pkg::SUM_W-1];
            mag  = neg ? (~s + 1'b1) : s;
            p    = PROD_W'(mag) * PROD_W'(RECIP_125);
            amag = p[RECIP_SHIFT +: MAG_W];
            if (gai_pkg::sum_out_of_range(s))
                return '0;
            return neg ? -{1'b0, amag} : {1'b0, amag};
        end
    endfunction

    logic [31:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= {2'b00, to_angle(snap_z), to_angle(snap_y), to_angle(snap_x)};
    end

    assign data = data_reg;

endmodule

/* hdl/gyro_angle_integrator_unit.sv */
// ----------------------------------------------------------------------------
// gyro_angle_integrator_unit: three-axis gyro angle integrator
// Remove the zero-rate offset, divide by 131, integrate per axis and
// report the three angles (sum*8/125) on every OUTPUT_EVERY-th sample.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  s_axis    in         tvalid/tready         tdata[47:0]  rate_x, rate_y, rate_z
//  m_axis    out        tvalid/tready         tdata[31:0]  angle_x, angle_y, angle_z
//  cfg       in         cfg_we (no wait)      cfg_addr, cfg_wdata  offset_x/y/z
//
//  One transfer per cycle is sustained while the result stream keeps up. An
//  accepted sample passes the quotient stage (multiply by reciprocal of 131),
//  the sum stage (saturating add and capture) and the result register (scale
//  by 8/125). The running sums close their loop in the sum stage, so samples
//  follow each other every cycle unless a stalled result holds them. Samples
//  that report nothing leave the first stage freely; a stalled result holds
//  only the stages behind it. Reset clears the offsets, the sums, the phase
//  counter and all valid flags.
module gyro_angle_integrator_unit
#(
    parameter int OUTPUT_EVERY = gai_pkg::OUTPUT_EVERY_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [47:0]                        s_axis_tdata,  // rate_x, rate_y, rate_z
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [31:0]                        m_axis_tdata,  // angle_x, angle_y, angle_z, pad
    input  logic                               cfg_we,
    input  logic [gai_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [gai_pkg::RATE_W-1:0]         cfg_wdata
);

    localparam int PHASE_W = (OUTPUT_EVERY > 1) ? $clog2(OUTPUT_EVERY) : 1;
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(OUTPUT_EVERY - 1);

    // configuration registers
    logic signed [gai_pkg::RATE_W-1:0] offset_x_reg;
    logic signed [gai_pkg::RATE_W-1:0] offset_y_reg;
    logic signed [gai_pkg::RATE_W-1:0] offset_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (gai_pkg::cfg_reg_t'(cfg_addr))
                gai_pkg::REG_OFFSET_X: offset_x_reg <= cfg_wdata;
                gai_pkg::REG_OFFSET_Y: offset_y_reg <= cfg_wdata;
                gai_pkg::REG_OFFSET_Z: offset_z_reg <= cfg_wdata;
                default:               ; // drop writes beyond the register list
            endcase
        end
    end

    // pipeline control
    logic               valid_a_reg;
    logic               emit_a_reg;
    logic               valid_b_reg;
    logic               valid_c_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;

    logic               ready_c;
    logic               ready_b;
    logic               ready_a;
    logic               accept;
    logic               adv_a;
    logic               adv_b;
    gai_pkg::lane_ctrl_t lane_ctrl;

    assign ready_c = !valid_c_reg || m_axis_tready;
    assign ready_b = !valid_b_reg || ready_c;
    // a sample that reports nothing never waits on the stages behind it
    assign ready_a = !valid_a_reg || !emit_a_reg || ready_b;
    assign accept  = s_axis_tvalid && ready_a;
    assign adv_a   = valid_a_reg && ready_a;
    assign adv_b   = valid_b_reg && ready_c;

    assign phase_next = (phase_reg == PHASE_LAST) ? '0 : phase_reg + 1'b1;

    assign lane_ctrl.load_a = accept;
    assign lane_ctrl.adv_a  = adv_a;
    assign lane_ctrl.emit_a = emit_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            emit_a_reg  <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            phase_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                valid_a_reg <= 1'b1;
                emit_a_reg  <= (phase_reg == '0);
                phase_reg   <= phase_next;
            end
            else if (adv_a)
            begin
                valid_a_reg <= 1'b0;
            end

            if (adv_a && emit_a_reg)
                valid_b_reg <= 1'b1;
            else if (adv_b)
                valid_b_reg <= 1'b0;

            if (adv_b)
                valid_c_reg <= 1'b1;
            else if (m_axis_tready)
                valid_c_reg <= 1'b0;
        end
    end

    // lanes
    logic signed [gai_pkg::SUM_W-1:0] snap_x;
    logic signed [gai_pkg::SUM_W-1:0] snap_y;
    logic signed [gai_pkg::SUM_W-1:0] snap_z;

    gai_lane u_lane_x
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .rate   (s_axis_tdata[15:0]),
        .offset (offset_x_reg),
        .snap   (snap_x)
    );

    gai_lane u_lane_y
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .rate   (s_axis_tdata[31:16]),
        .offset (offset_y_reg),
        .snap   (snap_y)
    );

    gai_lane u_lane_z
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .rate   (s_axis_tdata[47:32]),
        .offset (offset_z_reg),
        .snap   (snap_z)
    );

    // merge the three sums into one result word
    gai_merge u_merge
    (
        .clk    (clk),
        .load   (adv_b),
        .snap_x (snap_x),
        .snap_y (snap_y),
        .snap_z (snap_z),
        .data   (m_axis_tdata)
    );

    assign s_axis_tready = ready_a;
    assign m_axis_tvalid = valid_c_reg;

    // a result appears only from a captured sum snapshot
    a_result_from_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_c_reg) |-> $past(valid_b_reg))
        else $error("result raised without a captured snapshot");

    // a snapshot waiting on a stalled result register is held
    a_snapshot_held: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_b_reg && !ready_c) |=> valid_b_reg)
        else $error("snapshot lost while result stalled");

    // the first sample of each group is marked to report
    a_emit_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == '0) |=> (valid_a_reg && emit_a_reg))
        else $error("reporting sample not marked");

    // phase stays within one group
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PHASE_LAST)
        else $error("sample phase out of range");

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the gyro angle integrator
// Streams three-axis rate samples into the block, integrates them in a
// local angle tracker and compares every reported angle triple against it,
// over several offset settings with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_EVERY  = gai_pkg::OUTPUT_EVERY_DEF;
    localparam int RATE_DIVISOR  = 131;
    localparam int SUM_CEIL      = 8191;
    localparam int SUM_FLOOR     = -8192;
    localparam int SETTLE_CYCLES = 8;        // pipeline is three deep; allow margin
    localparam int HOLD_CYCLES   = 400;      // long receiver hold-off
    localparam int HOLD_AFTER    = 150;      // samples accepted before the hold-off
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_SAMPLES = 80;

    typedef enum int {RATE_NOISE, RATE_CREEP, RATE_SURGE, RATE_HOVER} rate_shape_t;

    // ------------------------------------------------------------------------
    // Angle tracker: integrates accepted samples the way the block should and
    // queues the angle triple due on every reporting sample.
    // ------------------------------------------------------------------------
    class angle_tracker;
        int          offset [3];
        int          running_sum [3];
        int          sample_phase;
        logic [29:0] expected_angles [$];
        int          mismatches;
        string       field_name [3] = '{"angle_x", "angle_y", "angle_z"};

        function new();
            for (int i = 0; i < 3; i++)
            begin
                offset[i]      = 0;
                running_sum[i] = 0;
            end
            sample_phase = 0;
            mismatches   = 0;
        endfunction

        function void set_offsets(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz);
            offset[0] = int'($signed(ox));
            offset[1] = int'($signed(oy));
            offset[2] = int'($signed(oz));
        endfunction

        function int pending();
            return expected_angles.size();
        endfunction

        // wrap the offset difference to 16 bits, divide toward zero, saturate
        function void integrate(int axis, logic [15:0] rate);
            logic signed [15:0] diff;
            int                 s;
            diff = 16'(int'($signed(rate)) - offset[axis]);
            s = running_sum[axis] + int'(diff) / RATE_DIVISOR;
            if (s > SUM_CEIL)
                s = SUM_CEIL;
            if (s < SUM_FLOOR)
                s = SUM_FLOOR;
            running_sum[axis] = s;
        endfunction

        // angle = sum*8/125 toward zero; out of range reports 0 and clears
        function logic [9:0] angle_of(int axis);
            int a;
            a = (running_sum[axis] * 8) / 125;
            if (a > gai_pkg::ANGLE_LIMIT || a < -gai_pkg::ANGLE_LIMIT)
            begin
                a = 0;
                running_sum[axis] = 0;
            end
            return 10'(a);
        endfunction

        function void take_sample(logic [47:0] word);
            logic        due;
            logic [29:0] angles;
            due = (sample_phase == 0);
            for (int i = 0; i < 3; i++)
                integrate(i, word[i*16 +: 16]);
            sample_phase = (sample_phase + 1) % REPORT_EVERY;
            if (due)
            begin
                for (int i = 0; i < 3; i++)
                    angles[i*10 +: 10] = angle_of(i);
                expected_angles.push_back(angles);
            end
        endfunction

        function void check_angles(logic [31:0] word);
            logic [29:0] want;
            if (expected_angles.size() == 0)
            begin
                $error("angle result %h arrived with none expected", word);
                mismatches++;
                return;
            end
            want = expected_angles.pop_front();
            for (int i = 0; i < 3; i++)
            begin
                if (word[i*10 +: 10] !== want[i*10 +: 10])
                begin
                    $error("%s mismatch: expected %0d, actual %0d", field_name[i],
                           $signed(want[i*10 +: 10]), $signed(word[i*10 +: 10]));
                    mismatches++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block connections
    // ------------------------------------------------------------------------
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;      // rate_x, rate_y, rate_z
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;            // angle_x, angle_y, angle_z, pad
    logic        cfg_we        = 1'b0;
    logic [gai_pkg::CFG_IDX_W-1:0] cfg_addr = gai_pkg::REG_OFFSET_X;
    logic [gai_pkg::RATE_W-1:0]    cfg_wdata = '0;

    logic        no_idle    = 1'b0;       // both streams run without gaps
    int          samples_in = 0;          // accepted input transfers
    int          cycle_count = 0;

    angle_tracker tracker;

    always #5 clk = ~clk;

    gyro_angle_integrator_unit #(
        .OUTPUT_EVERY (REPORT_EVERY)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Receiver: drop tready at random about 31 times in a hundred, never while
    // no_idle is set, and once hold it low for a long stretch so that the
    // result stage backs up and the block refuses further samples.
    // ------------------------------------------------------------------------
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (!hold_done && samples_in >= HOLD_AFTER)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
        end
        else
        begin
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 31);
        end
    end

    // Check every output transfer against the oldest expected triple
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_angles(m_axis_tdata);
    end

    // Hard stop should the block hang
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks; each is entered and left just after a rising edge
    // ------------------------------------------------------------------------

    // Offer one sample, idling first at random, and hold it until transferred
    task automatic send_sample(input logic [15:0] rx, input logic [15:0] ry,
                               input logic [15:0] rz);
        while (!no_idle && $urandom_range(0, 99) < 31)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rz, ry, rx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.take_sample({rz, ry, rx});
        samples_in <= samples_in + 1;
    endtask

    // Stop offering, wait for every expected triple, then let the pipeline
    // empty of samples that report nothing
    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three offsets, then poke the unused index, which must be ignored
    task automatic load_offsets(input logic [15:0] ox, input logic [15:0] oy,
                                input logic [15:0] oz);
        cfg_we    <= 1'b1;
        cfg_addr  <= gai_pkg::REG_OFFSET_X;
        cfg_wdata <= ox;
        @(posedge clk);
        cfg_addr  <= gai_pkg::REG_OFFSET_Y;
        cfg_wdata <= oy;
        @(posedge clk);
        cfg_addr  <= gai_pkg::REG_OFFSET_Z;
        cfg_wdata <= oz;
        @(posedge clk);
        cfg_addr  <= gai_pkg::REG_UNUSED;
        cfg_wdata <= 16'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
        tracker.set_offsets(ox, oy, oz);
    endtask

    // Pick a raw sample so that the offset-corrected rate has the wanted shape:
    // slow creep walks the angle across the 360 boundary in small steps, a
    // surge overshoots it quickly, hover stays near zero, noise is anything
    function automatic logic [15:0] shaped_rate(rate_shape_t shape, bit neg, int off);
        int d;
        case (shape)
            RATE_CREEP: d = $urandom_range(0, 1500);
            RATE_SURGE: d = $urandom_range(20000, 32767);
            RATE_HOVER: d = int'($urandom_range(0, 600)) - 300;
            default:    return 16'($urandom);
        endcase
        if (neg)
            d = -d;
        return 16'(off + d);
    endfunction

    // Drive runs of shaped samples, each axis with its own shape per run
    task automatic drive_runs(input int count);
        rate_shape_t shape [3];
        bit          neg [3];
        int          run_len;
        int          pick;
        logic [15:0] r [3];
        while (count > 0)
        begin
            run_len = $urandom_range(6, 40);
            for (int i = 0; i < 3; i++)
            begin
                pick = $urandom_range(0, 9);
                shape[i] = (pick < 2) ? RATE_NOISE :
                           (pick < 5) ? RATE_CREEP :
                           (pick < 8) ? RATE_SURGE : RATE_HOVER;
                neg[i] = $urandom_range(0, 1);
            end
            for (int n = 0; n < run_len && count > 0; n++)
            begin
                for (int i = 0; i < 3; i++)
                    r[i] = shaped_rate(shape[i], neg[i], tracker.offset[i]);
                send_sample(r[0], r[1], r[2]);
                count--;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero offsets: field extremes and division truncating toward zero
        send_sample(16'sd32767, -16'sd32768, 16'sd0);
        send_sample(-16'sd32768, 16'sd32767, 16'sd130);
        send_sample(16'sd131, -16'sd131, -16'sd130);
        send_sample(16'sd130, -16'sd130, 16'sd131);
        send_sample(16'sd0, 16'sd0, -16'sd131);
        send_sample(-16'sd1, 16'sd1, 16'sd32767);

        // Extreme offsets: the difference wraps at 16 bits before dividing
        drain_and_settle();
        load_offsets(16'sd32767, -16'sd32768, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd32767);
        send_sample(16'sd32767, -16'sd32768, -16'sd32768);
        send_sample(16'h5555, 16'haaaa, 16'h5555);
        send_sample(16'haaaa, 16'h5555, 16'haaaa);
        send_sample(16'h8001, 16'h7ffe, 16'h0001);

        // Random phases, each under its own offsets; the third runs gap-free
        for (int p = 0; p < 5; p++)
        begin
            drain_and_settle();
            case (p)
                0:       load_offsets(16'sd0, 16'sd0, 16'sd0);
                1:       load_offsets(16'sd32767, -16'sd32768, 16'($urandom));
                3:       load_offsets(-16'sd32768, 16'sd32767, 16'sd0);
                default: load_offsets(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            no_idle <= (p == 2);
            drive_runs(PHASE_SAMPLES);
        end

        drain_and_settle();
        if (tracker.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
